/* hw/rtl/bpc_pkg.sv */
// Shared types and constants for the barometric compensation pipeline.
package bpc_pkg;

  localparam int CAL_W      = 16;
  localparam int RAW_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int TEMP_OUT_W = 15;
  localparam int PRES_OUT_W = 17;

  // Internal datapath widths, sized to the worst-case calibration and raw inputs.
  localparam int DT_W      = 25;
  localparam int PROD_W    = 42;
  localparam int DD_W      = 50;
  localparam int Q_W       = 18;
  localparam int T2_W      = 18;
  localparam int TEMP_W    = 20;
  localparam int SQ_W      = 35;
  localparam int SQ5_W     = 37;
  localparam int OFF_W     = 38;
  localparam int SENS_W    = 37;
  localparam int SENS_LO_W = 18;
  localparam int SENS_HI_W = SENS_W - SENS_LO_W;
  localparam int PL_W      = RAW_W + SENS_LO_W;
  localparam int PH_W      = RAW_W + 1 + SENS_HI_W;
  localparam int PD_W      = 62;
  localparam int DIFF_W    = 42;
  localparam int PRES_W    = 27;

  // Register stages from the input register to the last datapath stage.
  localparam int PIPE_DEPTH = 10;

  localparam int C1_SHIFT       = 15;
  localparam int C2_SHIFT       = 16;
  localparam int C5_SHIFT       = 8;
  localparam int OFF_TC_SHIFT   = 7;
  localparam int SENS_TC_SHIFT  = 8;
  localparam int TEMP_DIV_SHIFT = 23;
  localparam int T2_SHIFT       = 31;
  localparam int SENS_SHIFT     = 21;
  localparam int PRES_DIV_SHIFT = 15;

  localparam longint TEMP_DIV_M1 = 64'sd8388607;
  localparam longint PRES_DIV_M1 = 64'sd32767;

  localparam int TEMP_REF     = 2000;
  localparam int TEMP_OUT_MIN = -4000;
  localparam int TEMP_OUT_MAX = 8500;
  localparam int PRES_OUT_MAX = 131071;

  // Calibration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_C1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_C3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_C4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_C5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_C6 = 3'd5;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } bpc_cal_t;

  typedef struct packed {
    logic signed [TEMP_OUT_W-1:0] temperature_centi;
    logic [PRES_OUT_W-1:0]        pressure_pa;
    logic                         clamped;
  } bpc_result_t;

endpackage

/* hw/rtl/bpc_datapath.sv */
// Ten-stage compensation datapath with output saturation.
module bpc_datapath (
  input  logic                      clk,
  input  logic                      en,
  input  bpc_pkg::bpc_cal_t         cal,
  input  logic [bpc_pkg::RAW_W-1:0] raw_pressure,
  input  logic [bpc_pkg::RAW_W-1:0] raw_temperature,
  output bpc_pkg::bpc_result_t      result
);
  import bpc_pkg::*;

  localparam logic signed [TEMP_W-1:0] T_MIN = TEMP_W'(TEMP_OUT_MIN);
  localparam logic signed [TEMP_W-1:0] T_MAX = TEMP_W'(TEMP_OUT_MAX);
  localparam logic signed [PRES_W-1:0] P_MAX = PRES_W'(PRES_OUT_MAX);

  // Stage 1: temperature difference
  logic [RAW_W-1:0]        d1_1_r;
  logic signed [DT_W-1:0]  dt_1_r, dt_1_nxt;
  // Stage 2: calibration products
  logic [RAW_W-1:0]         d1_2_r;
  logic signed [PROD_W-1:0] pc4_2_r, pc3_2_r, pc6_2_r;
  logic signed [PROD_W-1:0] pc4_2_nxt, pc3_2_nxt, pc6_2_nxt;
  logic signed [DD_W-1:0]   pdd_2_r, pdd_2_nxt;
  // Stage 3: first-order offset, sensitivity, temperature quotient
  logic [RAW_W-1:0]         d1_3_r;
  logic signed [OFF_W-1:0]  off1_3_r, off1_3_nxt;
  logic signed [SENS_W-1:0] sens1_3_r, sens1_3_nxt;
  logic signed [Q_W-1:0]    q_3_r, q_3_nxt;
  logic [T2_W-1:0]          t2_3_r, t2_3_nxt;
  logic signed [PROD_W-1:0] q_bias, q_sum;
  // Stage 4: cold flag, square, temperature
  logic [RAW_W-1:0]         d1_4_r;
  logic signed [OFF_W-1:0]  off1_4_r;
  logic signed [SENS_W-1:0] sens1_4_r;
  logic                     low_4_r, low_4_nxt;
  logic [SQ_W-1:0]          sq_4_r, sq_4_nxt;
  logic signed [TEMP_W-1:0] temp_4_r, temp_4_nxt;
  logic [TEMP_W-1:0]        t2_sub;
  // Stage 5: five times the square
  logic [RAW_W-1:0]         d1_5_r;
  logic signed [OFF_W-1:0]  off1_5_r;
  logic signed [SENS_W-1:0] sens1_5_r;
  logic signed [TEMP_W-1:0] temp_5_r;
  logic [SQ5_W-1:0]         sq5_5_r, sq5_5_nxt;
  // Stage 6: second-order offset and sensitivity
  logic [RAW_W-1:0]         d1_6_r;
  logic signed [OFF_W-1:0]  off_6_r, off_6_nxt;
  logic signed [SENS_W-1:0] sens_6_r, sens_6_nxt;
  logic signed [TEMP_W-1:0] temp_6_r;
  // Stage 7: split pressure product
  logic [PL_W-1:0]          pl_7_r, pl_7_nxt;
  logic signed [PH_W-1:0]   ph_7_r, ph_7_nxt;
  logic signed [OFF_W-1:0]  off_7_r;
  logic signed [TEMP_W-1:0] temp_7_r;
  // Stage 8: recombined product
  logic signed [PD_W-1:0]   prod_8_r, prod_8_nxt;
  logic signed [OFF_W-1:0]  off_8_r;
  logic signed [TEMP_W-1:0] temp_8_r;
  // Stage 9: scaled product minus offset
  logic signed [DIFF_W-1:0] diff_9_r, diff_9_nxt;
  logic signed [TEMP_W-1:0] temp_9_r;
  // Stage 10: pressure quotient
  logic signed [PRES_W-1:0] pres_10_r, pres_10_nxt;
  logic signed [TEMP_W-1:0] temp_10_r;
  logic signed [DIFF_W-1:0] p_bias, p_sum;

  always_comb begin
    dt_1_nxt = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'b0});

    pc4_2_nxt = $signed({1'b0, cal.c4}) * dt_1_r;
    pc3_2_nxt = $signed({1'b0, cal.c3}) * dt_1_r;
    pc6_2_nxt = $signed({1'b0, cal.c6}) * dt_1_r;
    pdd_2_nxt = dt_1_r * dt_1_r;

    off1_3_nxt  = $signed({{(OFF_W - CAL_W - C2_SHIFT){1'b0}}, cal.c2, {C2_SHIFT{1'b0}}})
                + OFF_W'(pc4_2_r >>> OFF_TC_SHIFT);
    sens1_3_nxt = $signed({{(SENS_W - CAL_W - C1_SHIFT){1'b0}}, cal.c1, {C1_SHIFT{1'b0}}})
                + SENS_W'(pc3_2_r >>> SENS_TC_SHIFT);
    // Round the quotient toward zero: bias negative products before the shift.
    q_bias   = pc6_2_r[PROD_W-1] ? PROD_W'(TEMP_DIV_M1) : '0;
    q_sum    = pc6_2_r + q_bias;
    q_3_nxt  = Q_W'(q_sum >>> TEMP_DIV_SHIFT);
    t2_3_nxt = T2_W'(pdd_2_r >>> T2_SHIFT);

    low_4_nxt  = q_3_r[Q_W-1];
    sq_4_nxt   = SQ_W'(q_3_r * q_3_r);
    t2_sub     = q_3_r[Q_W-1] ? {{(TEMP_W - T2_W){1'b0}}, t2_3_r} : '0;
    temp_4_nxt = TEMP_W'(TEMP_REF) + TEMP_W'(q_3_r) - $signed(t2_sub);

    sq5_5_nxt = low_4_r ? (SQ5_W'(sq_4_r) + (SQ5_W'(sq_4_r) << 2)) : '0;

    off_6_nxt  = off1_5_r - $signed({1'b0, sq5_5_r[SQ5_W-1:1]});
    sens_6_nxt = sens1_5_r - $signed({2'b0, sq5_5_r[SQ5_W-1:2]});

    pl_7_nxt = d1_6_r * sens_6_r[SENS_LO_W-1:0];
    ph_7_nxt = $signed({1'b0, d1_6_r}) * $signed(sens_6_r[SENS_W-1:SENS_LO_W]);

    prod_8_nxt = (PD_W'(ph_7_r) <<< SENS_LO_W) + $signed({{(PD_W - PL_W){1'b0}}, pl_7_r});

    diff_9_nxt = DIFF_W'(prod_8_r >>> SENS_SHIFT) - DIFF_W'(off_8_r);

    p_bias      = diff_9_r[DIFF_W-1] ? DIFF_W'(PRES_DIV_M1) : '0;
    p_sum       = diff_9_r + p_bias;
    pres_10_nxt = PRES_W'(p_sum >>> PRES_DIV_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_1_r <= raw_pressure;
      dt_1_r <= dt_1_nxt;

      d1_2_r  <= d1_1_r;
      pc4_2_r <= pc4_2_nxt;
      pc3_2_r <= pc3_2_nxt;
      pc6_2_r <= pc6_2_nxt;
      pdd_2_r <= pdd_2_nxt;

      d1_3_r    <= d1_2_r;
      off1_3_r  <= off1_3_nxt;
      sens1_3_r <= sens1_3_nxt;
      q_3_r     <= q_3_nxt;
      t2_3_r    <= t2_3_nxt;

      d1_4_r    <= d1_3_r;
      off1_4_r  <= off1_3_r;
      sens1_4_r <= sens1_3_r;
      low_4_r   <= low_4_nxt;
      sq_4_r    <= sq_4_nxt;
      temp_4_r  <= temp_4_nxt;

      d1_5_r    <= d1_4_r;
      off1_5_r  <= off1_4_r;
      sens1_5_r <= sens1_4_r;
      temp_5_r  <= temp_4_r;
      sq5_5_r   <= sq5_5_nxt;

      d1_6_r   <= d1_5_r;
      off_6_r  <= off_6_nxt;
      sens_6_r <= sens_6_nxt;
      temp_6_r <= temp_5_r;

      pl_7_r   <= pl_7_nxt;
      ph_7_r   <= ph_7_nxt;
      off_7_r  <= off_6_r;
      temp_7_r <= temp_6_r;

      prod_8_r <= prod_8_nxt;
      off_8_r  <= off_7_r;
      temp_8_r <= temp_7_r;

      diff_9_r <= diff_9_nxt;
      temp_9_r <= temp_8_r;

      pres_10_r <= pres_10_nxt;
      temp_10_r <= temp_9_r;
    end
  end

  // Saturate to the output ranges.
  always_comb begin
    result.clamped = 1'b0;
    if (temp_10_r < T_MIN) begin
      result.temperature_centi = TEMP_OUT_W'(T_MIN);
      result.clamped           = 1'b1;
    end else if (temp_10_r > T_MAX) begin
      result.temperature_centi = TEMP_OUT_W'(T_MAX);
      result.clamped           = 1'b1;
    end else begin
      result.temperature_centi = TEMP_OUT_W'(temp_10_r);
    end
    if (pres_10_r < 0) begin
      result.pressure_pa = '0;
      result.clamped     = 1'b1;
    end else if (pres_10_r > P_MAX) begin
      result.pressure_pa = PRES_OUT_W'(P_MAX);
      result.clamped     = 1'b1;
    end else begin
      result.pressure_pa = PRES_OUT_W'(pres_10_r);
    end
  end

endmodule

/* hw/rtl/baro_pressure_temp_compensation_unit.sv */
// Top level of the barometric second-order compensation unit.
// Ten datapath stages plus the output register: an accepted transaction moves through the
// datapath stages and then the output register, whose contents show on out_valid.
// Throughput: one transaction per cycle unless a full output register is stalled.
// A stalled output register freezes every stage at once: in_stall = out_valid && out_stall.
// Reset (rst_n low, synchronous) clears all valid bits and the six calibration words.
module baro_pressure_temp_compensation_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [bpc_pkg::RAW_W-1:0]             in_raw_pressure,
  input  logic [bpc_pkg::RAW_W-1:0]             in_raw_temperature,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [bpc_pkg::TEMP_OUT_W-1:0] out_temperature_centi,
  output logic [bpc_pkg::PRES_OUT_W-1:0]        out_pressure_pa,
  output logic                                  out_clamped,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bpc_pkg::CAL_W-1:0]             cfg_wdata
);
  import bpc_pkg::*;

  bpc_cal_t              cal_r, cal_nxt;
  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;
  logic                  out_valid_r;
  logic                  adv;
  bpc_result_t           dp_result;
  bpc_result_t           res_r;

  // Advance the whole pipeline whenever the output register is free or drains.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Calibration words; indexes past the last word drop the write.
  always_comb begin
    cal_nxt = cal_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_C1:  cal_nxt.c1 = cfg_wdata;
        CFG_C2:  cal_nxt.c2 = cfg_wdata;
        CFG_C3:  cal_nxt.c3 = cfg_wdata;
        CFG_C4:  cal_nxt.c4 = cfg_wdata;
        CFG_C5:  cal_nxt.c5 = cfg_wdata;
        CFG_C6:  cal_nxt.c6 = cfg_wdata;
        default: cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  // Valid bits ride alongside the datapath stages; a bubble enters when in_valid is low.
  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  bpc_datapath u_datapath (
    .clk             (clk),
    .en              (adv),
    .cal             (cal_r),
    .raw_pressure    (in_raw_pressure),
    .raw_temperature (in_raw_temperature),
    .result          (dp_result)
  );

  // Output register: hold the transaction while the receiver stalls.
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= dp_result;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = res_r.temperature_centi;
  assign out_pressure_pa       = res_r.pressure_pa;
  assign out_clamped           = res_r.clamped;

endmodule

/* hw/rtl/bpc_checker.sv */
// Port-level checks for the compensation unit, bound to the top level.
module bpc_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [bpc_pkg::TEMP_OUT_W-1:0] out_temperature_centi,
  input logic [bpc_pkg::PRES_OUT_W-1:0]        out_pressure_pa,
  input logic                                  out_clamped
);
  import bpc_pkg::*;

  // Hold a stalled result transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // Back-pressure reaches the input only through a full, stalled output register.
  a_stall_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the output register");

  // Temperature always lands inside its saturation range.
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_centi >= TEMP_OUT_MIN) &&
                  (out_temperature_centi <= TEMP_OUT_MAX))
    else $error("temperature outside saturation range");

  // Both values strictly inside their ranges means nothing was clamped.
  a_clamp_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_temperature_centi > TEMP_OUT_MIN) &&
    (out_temperature_centi < TEMP_OUT_MAX) && (out_pressure_pa != '0) &&
    (out_pressure_pa != PRES_OUT_W'(PRES_OUT_MAX)) |-> !out_clamped)
    else $error("clamped flag set without saturation");

endmodule

bind baro_pressure_temp_compensation_unit bpc_checker u_bpc_checker (.*);

/* verif/baro_pressure_temp_compensation_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the barometric second-order compensation unit.
module baro_pressure_temp_compensation_unit_test;
  import bpc_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int MAX_IDLE        = 18;
  // Longer than the output register plus ten datapath stages; wait this long before touching config.
  localparam int PIPE_LATENCY    = 12;
  localparam int PHASES          = 11;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int TIMEOUT_CYCLES  = 500000;
  localparam int N_DIRECTED      = 18;

  // Indexes past the last calibration word; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CAL_REG_INDEX [6] =
    '{CFG_C1, CFG_C2, CFG_C3, CFG_C4, CFG_C5, CFG_C6};

  // Calibration sets used by the directed table.
  localparam bpc_cal_t CAL_ZERO = '0;
  localparam bpc_cal_t CAL_SPEC = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                                    c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
  localparam bpc_cal_t CAL_COLD = '{c1: 16'd0, c2: 16'd0, c3: 16'd0,
                                    c4: 16'd0, c5: 16'hFFFF, c6: 16'hFFFF};
  localparam bpc_cal_t CAL_NEG  = '{c1: 16'd0, c2: 16'hFFFF, c3: 16'd0,
                                    c4: 16'd0, c5: 16'd0, c6: 16'd0};
  localparam bpc_cal_t CAL_HOT  = '{c1: 16'd0, c2: 16'd0, c3: 16'd0,
                                    c4: 16'd0, c5: 16'd0, c6: 16'hFFFF};
  localparam bpc_cal_t CAL_MAX  = '1;

  localparam logic [RAW_W-1:0] RAW_MAX = '1;

  typedef struct packed {
    bpc_cal_t         cal;
    logic [RAW_W-1:0] raw_p;
    logic [RAW_W-1:0] raw_t;
    logic             typed;   // 1: use the result typed in the row
    bpc_result_t      want;
  } stim_row_t;

  localparam bpc_result_t NONE = '0;

  // Directed rows. Typed results are those that can be worked out by hand:
  // zero calibration after reset, the published worked example, and the clamps.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{CAL_ZERO, 24'd0,       24'd0,       1'b1, '{15'sd2000, 17'd0, 1'b0}},
    '{CAL_ZERO, RAW_MAX,     RAW_MAX,     1'b1, '{15'sd2000, 17'd0, 1'b0}},
    '{CAL_ZERO, 24'hAAAAAA,  24'h555555,  1'b1, '{15'sd2000, 17'd0, 1'b0}},
    '{CAL_SPEC, 24'd9085466, 24'd8569150, 1'b1, '{15'sd2007, 17'd100009, 1'b0}},
    '{CAL_SPEC, 24'd0,       24'd8569150, 1'b0, NONE},
    '{CAL_SPEC, RAW_MAX,     24'd8569150, 1'b0, NONE},
    // just below the reference: temperature stays at 20.00 C, no correction
    '{CAL_SPEC, 24'd9085466, 24'd8566783, 1'b0, NONE},
    // first step below 20.00 C: second-order terms kick in
    '{CAL_SPEC, 24'd9085466, 24'd8566484, 1'b0, NONE},
    // below -15.00 C: still only the one correction
    '{CAL_SPEC, 24'd9085466, 24'd7500000, 1'b0, NONE},
    '{CAL_SPEC, 24'd9085466, 24'd0,       1'b0, NONE},
    '{CAL_SPEC, 24'd9085466, RAW_MAX,     1'b0, NONE},
    // far below range: temperature to the floor, pressure to the ceiling
    '{CAL_COLD, 24'd0,       24'd0,       1'b1, '{-15'sd4000, 17'd131071, 1'b1}},
    '{CAL_COLD, RAW_MAX,     24'd0,       1'b0, NONE},
    // offset beats sensitivity: negative pressure reads as zero
    '{CAL_NEG,  24'd0,       24'd0,       1'b1, '{15'sd2000, 17'd0, 1'b1}},
    '{CAL_HOT,  24'h123456,  RAW_MAX,     1'b1, '{15'sd8500, 17'd0, 1'b1}},
    '{CAL_MAX,  24'd0,       24'd0,       1'b0, NONE},
    '{CAL_MAX,  RAW_MAX,     RAW_MAX,     1'b0, NONE},
    '{CAL_MAX,  RAW_MAX,     24'hFFFF00,  1'b0, NONE}
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [RAW_W-1:0]               in_raw_pressure = '0;
  logic [RAW_W-1:0]               in_raw_temperature = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [TEMP_OUT_W-1:0]   out_temperature_centi;
  logic [PRES_OUT_W-1:0]          out_pressure_pa;
  logic                           out_clamped;
  logic                           cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]           cfg_index = '0;
  logic [CAL_W-1:0]               cfg_wdata = '0;

  bpc_cal_t    cal_shadow = '0;      // calibration words as the block should hold them
  bpc_result_t pending_readings[$];  // expected results in order of acceptance
  bit          sender_steady = 1'b0;
  bit          receiver_steady = 1'b0;
  int          mismatch_count = 0;
  int          readings_checked = 0;
  int          samples_sent = 0;
  int          cal_loads = 0;

  baro_pressure_temp_compensation_unit i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_raw_pressure       (in_raw_pressure),
    .in_raw_temperature    (in_raw_temperature),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_pa       (out_pressure_pa),
    .out_clamped           (out_clamped),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Integer compensation in 64-bit signed arithmetic. Shifts of signed values
  // floor (>>>), divisions truncate toward zero, as the datapath does.
  function automatic bpc_result_t compensate_reading(input bpc_cal_t cal,
                                                     input logic [RAW_W-1:0] raw_p,
                                                     input logic [RAW_W-1:0] raw_t);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint delta_t, offset, sens, temp, pres, dev_sq;
    bpc_result_t r;
    d1 = longint'(raw_p);
    d2 = longint'(raw_t);
    c1 = longint'(cal.c1);
    c2 = longint'(cal.c2);
    c3 = longint'(cal.c3);
    c4 = longint'(cal.c4);
    c5 = longint'(cal.c5);
    c6 = longint'(cal.c6);
    r.clamped = 1'b0;

    delta_t = d2 - (c5 << C5_SHIFT);
    offset  = (c2 << C2_SHIFT) + ((c4 * delta_t) >>> OFF_TC_SHIFT);
    sens    = (c1 << C1_SHIFT) + ((c3 * delta_t) >>> SENS_TC_SHIFT);
    temp    = TEMP_REF + (delta_t * c6) / (longint'(1) << TEMP_DIV_SHIFT);

    // Cold side: the square uses the first-order temperature.
    if (temp < TEMP_REF) begin
      dev_sq = (temp - TEMP_REF) * (temp - TEMP_REF);
      temp   = temp - ((delta_t * delta_t) >>> T2_SHIFT);
      offset = offset - ((5 * dev_sq) >>> 1);
      sens   = sens - ((5 * dev_sq) >>> 2);
    end

    pres = (((d1 * sens) >>> SENS_SHIFT) - offset) / (longint'(1) << PRES_DIV_SHIFT);

    if (temp < TEMP_OUT_MIN) begin
      temp = TEMP_OUT_MIN;
      r.clamped = 1'b1;
    end else if (temp > TEMP_OUT_MAX) begin
      temp = TEMP_OUT_MAX;
      r.clamped = 1'b1;
    end
    if (pres < 0) begin
      pres = 0;
      r.clamped = 1'b1;
    end else if (pres > PRES_OUT_MAX) begin
      pres = PRES_OUT_MAX;
      r.clamped = 1'b1;
    end
    r.temperature_centi = temp[TEMP_OUT_W-1:0];
    r.pressure_pa       = pres[PRES_OUT_W-1:0];
    return r;
  endfunction

  // Present one sample pair after a random gap, none while sender_steady, and hold it until
  // it is taken. Valid stays high on return so back-to-back samples need no extra edge.
  task automatic send_sample(input logic [RAW_W-1:0] raw_p,
                             input logic [RAW_W-1:0] raw_t,
                             input bpc_result_t want);
    int unsigned gap;
    gap = sender_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_raw_pressure    <= raw_p;
    in_raw_temperature <= raw_t;
    do @(posedge clk); while (in_stall);
    pending_readings.push_back(want);
    samples_sent++;
  endtask

  // Drop valid, let every expected result come back, then let the pipe go quiet.
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // Write one spare index (must be dropped), then all six calibration words.
  task automatic load_calibration(input bpc_cal_t cal);
    cfg_wr_en <= 1'b1;
    cfg_index <= $urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI;
    cfg_wdata <= CAL_W'($urandom_range(0, 65535));
    @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_index <= CAL_REG_INDEX[i];
      cfg_wdata <= cal[(5 - i) * CAL_W +: CAL_W];
      @(posedge clk);
      cal_shadow[(5 - i) * CAL_W +: CAL_W] = cal[(5 - i) * CAL_W +: CAL_W];
    end
    cfg_wr_en <= 1'b0;
    cal_loads++;
  endtask

  // Result side: stall for a random number of cycles, then take one transaction.
  initial begin
    int unsigned hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = receiver_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin
    bpc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected result: temperature_centi %0d pressure_pa %0d clamped %0b",
               out_temperature_centi, out_pressure_pa, out_clamped);
        mismatch_count++;
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        if (out_temperature_centi !== want.temperature_centi) begin
          $error("temperature_centi: expected %0d, got %0d",
                 want.temperature_centi, out_temperature_centi);
          mismatch_count++;
        end
        if (out_pressure_pa !== want.pressure_pa) begin
          $error("pressure_pa: expected %0d, got %0d", want.pressure_pa, out_pressure_pa);
          mismatch_count++;
        end
        if (out_clamped !== want.clamped) begin
          $error("clamped: expected %0b, got %0b", want.clamped, out_clamped);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random phases each with its own calibration.
  initial begin
    bpc_cal_t         next_cal;
    logic [RAW_W-1:0] raw_p;
    logic [RAW_W-1:0] raw_t;
    longint           t_guess;
    int unsigned      nominal;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: the first rows run on the reset calibration (all zero).
    foreach (directed_rows[k]) begin
      if (directed_rows[k].cal != cal_shadow) begin
        settle_pipeline();
        load_calibration(directed_rows[k].cal);
      end
      send_sample(directed_rows[k].raw_p, directed_rows[k].raw_t,
                  directed_rows[k].typed ? directed_rows[k].want :
                  compensate_reading(cal_shadow, directed_rows[k].raw_p,
                                     directed_rows[k].raw_t));
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      // Pick a calibration: all ones first, full random last, in between mostly a spread
      // around the worked example so most temperatures stay inside the range.
      case ((phase == 0) ? 0 : (phase == PHASES - 1) ? 1 : $urandom_range(0, 9))
        0: next_cal = CAL_MAX;
        1: next_cal = {$urandom, $urandom, $urandom};
        default: begin
          for (int i = 0; i < 6; i++) begin
            nominal = 32'(CAL_SPEC[i * CAL_W +: CAL_W]);
            next_cal[i * CAL_W +: CAL_W] = CAL_W'(nominal - nominal / 4 +
                                                  $urandom_range(0, nominal / 2));
          end
        end
      endcase
      settle_pipeline();
      load_calibration(next_cal);
      sender_steady   = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold off mid-phase once in a while until the pipe is empty.
        if (n == ITEMS_PER_PHASE / 2 && phase % 3 == 1) settle_pipeline();

        case ($urandom_range(0, 9))
          0: raw_p = $urandom_range(0, 1) ? RAW_MAX : '0;
          1, 2: raw_p = RAW_W'($urandom);
          default: raw_p = RAW_W'($urandom_range(6000000, 11000000));
        endcase

        case ($urandom_range(0, 9))
          0: raw_t = RAW_W'($urandom);
          1: raw_t = $urandom_range(0, 1) ? RAW_MAX : '0;
          default: begin
            // Around the reference point; a narrow window hits the 20.00 C edge.
            t_guess = longint'(cal_shadow.c5) << C5_SHIFT;
            if ($urandom_range(0, 3) == 0)
              t_guess = t_guess + $urandom_range(0, 1024) - 512;
            else
              t_guess = t_guess + $urandom_range(0, 4194304) - 2097152;
            if (t_guess < 0) t_guess = 0;
            if (t_guess > RAW_MAX) t_guess = RAW_MAX;
            raw_t = t_guess[RAW_W-1:0];
          end
        endcase

        send_sample(raw_p, raw_t, compensate_reading(cal_shadow, raw_p, raw_t));
      end
    end

    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY * 2) @(posedge clk);

    $display("Run covered %0d sample pairs under %0d calibration loads;", samples_sent,
             cal_loads);
    $display("%0d results compared, %0d field mismatches.", readings_checked,
             mismatch_count);
    if (mismatch_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
